// File: src/awe_pkg.sv
// Shared types and constants for the annotation word encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package awe_pkg;

  // Time arithmetic
  localparam int TIME_BITS    = 32;
  localparam int TIME_IN_BITS = 32;
  localparam int TM_BITS      = (TIME_BITS < TIME_IN_BITS) ? TIME_BITS : TIME_IN_BITS;
  localparam int SHIFT_BITS   = 31;
  localparam int T_BASE       = (TIME_BITS > SHIFT_BITS) ? TIME_BITS : SHIFT_BITS;
  localparam int T_BITS       = T_BASE + 2;   // signed shifted time
  localparam int D_BITS       = T_BITS + 1;   // signed delta

  // Word format
  localparam int TYPE_BITS  = 6;
  localparam int WORD_BITS  = 16;
  localparam int HALF_BITS  = 16;
  localparam int TYPE_SHIFT = WORD_BITS - TYPE_BITS;
  localparam logic [WORD_BITS-1:0] SKIP_WORD = 16'hEC00;
  localparam logic [WORD_BITS-1:0] NULL_WORD = 16'h0001;

  // Command queue between front and back
  localparam int CMD_DEPTH    = 2;
  localparam int CMD_PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [TIME_IN_BITS-1:0] ann_time;
    logic [TYPE_BITS-1:0]    ann_type;
  } ann_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] out_word;
    logic                 last_word;
  } word_t;

  typedef struct packed {
    logic                   long_form;
    logic [2*HALF_BITS-1:0] halves;
    logic [WORD_BITS-1:0]   final_word;
  } cmd_t;

  typedef enum logic [1:0] {
    SEQ_OPEN,
    SEQ_HIGH,
    SEQ_LOW,
    SEQ_FINAL
  } seq_state_t;

endpackage

// File: src/annotation_word_encoder.sv
// Annotation word encoder: turns annotations into 16-bit MIT format words.
//
// Channels (valid/ready, transaction when both high at a rising edge):
//   in_*  : one annotation, ann_time and ann_type (0 = null annotation).
//   out_* : one file word per transaction; last_word marks the final word
//           of an annotation.
//   cfg_* : write of time_shift, always ready; write only while idle.
// An annotation emits one word when its type is non-null and its delta lies
// in 0..1023, otherwise four words (SKIP, high half, low half, final word).
// The first word passes through the front-end register, the command queue
// and the output register. Throughput: the word sequencer emits one word
// per cycle while out_ready allows and a command is queued; the front end
// accepts one annotation per cycle while the two-entry command queue has
// room.
// Reset (rst, synchronous) clears time_shift and the previous time to zero
// and empties the pipeline. A stall on out_ready holds the output word,
// then fills the command queue, and only then drops in_ready.
// Depends on awe_pkg, awe_front, awe_cmd_fifo and awe_back.
`timescale 1ns / 1ps

module annotation_word_encoder import awe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ann_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output word_t                 out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SHIFT_BITS-1:0] cfg_data
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_head;

  awe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  awe_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .head      (cmd_head)
  );

  awe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/awe_front.sv
// Front end: holds the time shift, accepts annotations, forms the delta
// and classifies each one into a word command. Uses awe_pkg.
`timescale 1ns / 1ps

module awe_front import awe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ann_t                  in_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SHIFT_BITS-1:0] cfg_data,
  input  logic                  cmd_full,
  output logic                  cmd_push,
  output cmd_t                  cmd
);

  logic [SHIFT_BITS-1:0] time_shift;
  logic [T_BITS-1:0]     prev_time;

  logic                  a_valid;
  logic [T_BITS-1:0]     a_time;
  logic [TYPE_BITS-1:0]  a_type;

  logic [TM_BITS-1:0]    tm;
  logic [T_BITS-1:0]     t_in;
  logic [D_BITS-1:0]     delta;
  logic [D_BITS-1:0]     delta_m1;
  logic                  is_short;
  logic                  is_null;

  assign cfg_ready = 1'b1;

  // Time zero always maps to t = 1
  assign tm   = in_data.ann_time[TM_BITS-1:0];
  assign t_in = (tm == '0) ? T_BITS'(1) : (T_BITS'(tm) - T_BITS'(time_shift));

  assign cmd_push = a_valid && !cmd_full;
  assign in_ready = !a_valid || cmd_push;

  // delta - 1 is a_time + ~prev_time
  assign delta    = {a_time[T_BITS-1], a_time} - {prev_time[T_BITS-1], prev_time};
  assign delta_m1 = {a_time[T_BITS-1], a_time} + ~{prev_time[T_BITS-1], prev_time};
  assign is_short = !delta[D_BITS-1] && (delta[D_BITS-2:TYPE_SHIFT] == '0);
  assign is_null  = (a_type == '0);

  always_comb begin
    cmd.long_form = is_null || !is_short;
    cmd.halves    = is_null ? delta_m1[2*HALF_BITS-1:0] : delta[2*HALF_BITS-1:0];
    if (is_null) begin
      cmd.final_word = NULL_WORD;
    end else if (is_short) begin
      cmd.final_word = {a_type, delta[TYPE_SHIFT-1:0]};
    end else begin
      cmd.final_word = {a_type, {TYPE_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_shift <= '0;
      prev_time  <= '0;
      a_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_shift <= cfg_data;
      end
      if (cmd_push) begin
        prev_time <= a_time;
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_time <= t_in;
      a_type <= in_data.ann_type;
    end
  end

endmodule

// File: src/awe_cmd_fifo.sv
// Short command queue between the front end and the word sequencer.
// Uses cmd_t and queue sizing from awe_pkg.
`timescale 1ns / 1ps

module awe_cmd_fifo import awe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t                    entries [CMD_DEPTH];
  logic [CMD_PTR_BITS-1:0] wr_ptr;
  logic [CMD_PTR_BITS-1:0] rd_ptr;
  logic [CMD_CNT_BITS-1:0] count;

  function automatic logic [CMD_PTR_BITS-1:0] ptr_inc(input logic [CMD_PTR_BITS-1:0] p);
    ptr_inc = (p == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CMD_CNT_BITS'(CMD_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("command popped from an empty queue");

endmodule

// File: src/awe_back.sv
// Word sequencer: expands each queued command into file words and drives
// the output register. Uses awe_pkg.
`timescale 1ns / 1ps

module awe_back import awe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  output logic  cmd_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_data
);

  seq_state_t seq;
  seq_state_t seq_next;
  logic       advance;
  logic       load;
  word_t      word_next;

  assign advance = !out_valid || out_ready;

  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_OPEN: begin
        if (advance && cmd_valid && cmd.long_form) begin
          seq_next = SEQ_HIGH;
        end
      end
      SEQ_HIGH: begin
        if (advance) begin
          seq_next = SEQ_LOW;
        end
      end
      SEQ_LOW: begin
        if (advance) begin
          seq_next = SEQ_FINAL;
        end
      end
      SEQ_FINAL: begin
        if (advance) begin
          seq_next = SEQ_OPEN;
        end
      end
      default: seq_next = SEQ_OPEN;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    cmd_pop   = 1'b0;
    word_next = '{out_word: cmd.final_word, last_word: 1'b1};
    unique case (seq)
      SEQ_OPEN: begin
        load = advance && cmd_valid;
        if (cmd.long_form) begin
          word_next = '{out_word: SKIP_WORD, last_word: 1'b0};
        end else begin
          cmd_pop = advance && cmd_valid;
        end
      end
      SEQ_HIGH: begin
        load      = advance;
        word_next = '{out_word: cmd.halves[2*HALF_BITS-1:HALF_BITS], last_word: 1'b0};
      end
      SEQ_LOW: begin
        load      = advance;
        word_next = '{out_word: cmd.halves[HALF_BITS-1:0], last_word: 1'b0};
      end
      SEQ_FINAL: begin
        load    = advance;
        cmd_pop = advance;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_OPEN;
      out_valid <= 1'b0;
    end else begin
      seq       <= seq_next;
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word_next;
    end
  end

  a_mid_sequence_has_cmd: assert property (@(posedge clk) disable iff (rst)
    (seq != SEQ_OPEN) |-> cmd_valid)
    else $error("sequencer mid-command with no command queued");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (out_valid && out_data.last_word))
    else $error("command retired without a final word");

endmodule

// File: test/awe_word_checker.sv
// Checker for the annotation word encoder: watches the config, input and output channels,
// predicts the file words of every annotation and compares them. Depends on awe_pkg.
`timescale 1ns / 1ps

module awe_word_checker import awe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  ann_t                  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  word_t                 out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [SHIFT_BITS-1:0] cfg_data,
  output int                    words_due,
  output int                    fail_count
);

  localparam longint MAX_SHORT_DELTA = (1 << TYPE_SHIFT) - 1;

  logic [SHIFT_BITS-1:0] time_shift;
  longint                last_t;
  word_t                 pending_words[$];

  function automatic void encode_annotation(ann_t a);
    longint t_now;
    longint delta;
    longint wide;
    bit     null_ann;
    null_ann = (a.ann_type == '0);
    // time zero always maps to t = 1, whatever the shift
    if (a.ann_time[TM_BITS-1:0] == '0) begin
      t_now = 1;
    end else begin
      t_now = longint'(a.ann_time[TM_BITS-1:0]) - longint'(time_shift);
    end
    delta = t_now - last_t;
    if (null_ann || delta > MAX_SHORT_DELTA || delta < 0) begin
      wide = null_ann ? delta - 1 : delta;
      pending_words.push_back(word_t'{SKIP_WORD, 1'b0});
      pending_words.push_back(word_t'{wide[2*HALF_BITS-1:HALF_BITS], 1'b0});
      pending_words.push_back(word_t'{wide[HALF_BITS-1:0], 1'b0});
      delta = null_ann ? 1 : 0;
    end
    pending_words.push_back(word_t'{{a.ann_type, delta[TYPE_SHIFT-1:0]}, 1'b1});
    last_t = t_now;
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      time_shift = '0;
      last_t     = 0;
      fail_count = 0;
      pending_words.delete();
      words_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        time_shift = cfg_data;
      end
      if (in_valid && in_ready) begin
        encode_annotation(in_data);
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual %h last %b",
                   $time, out_data.out_word, out_data.last_word);
        end else begin
          want = pending_words.pop_front();
          if (out_data.out_word !== want.out_word) begin
            fail_count++;
            $display("%0t: out_word mismatch, expected %h, actual %h",
                     $time, want.out_word, out_data.out_word);
          end
          if (out_data.last_word !== want.last_word) begin
            fail_count++;
            $display("%0t: last_word mismatch, expected %b, actual %b",
                     $time, want.last_word, out_data.last_word);
          end
        end
      end
      words_due <= pending_words.size();
    end
  end

endmodule

// File: test/tb_annotation_word_encoder.sv
// Top of the annotation word encoder testbench: clock, reset, stimulus and verdict.
// Depends on awe_pkg, annotation_word_encoder and awe_word_checker.
`timescale 1ns / 1ps

module tb_annotation_word_encoder;
  import awe_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 400;
  localparam int                   MAX_GAP        = 18;
  localparam logic [TYPE_BITS-1:0] NULL_ANN       = '0;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MAX     = '1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  ann_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  word_t                 out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SHIFT_BITS-1:0] cfg_data  = '0;

  int                    words_due;
  int                    fail_count;
  int                    stall_left  = 0;
  int                    idle_cycles = 0;
  bit                    calm        = 1'b0;
  logic [TIME_IN_BITS-1:0] prev_ann_time = '0;

  always #2 clk = ~clk;

  annotation_word_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  awe_word_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .words_due  (words_due),
    .fail_count (fail_count)
  );

  function automatic int draw_gap(bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Receiver: after each word transaction, drop ready for a drawn number of cycles
  always @(posedge clk) begin
    int g;
    if (out_valid && out_ready) begin
      g = draw_gap(calm);
      if (g > 0) begin
        out_ready  <= 1'b0;
        stall_left <= g - 1;
      end
    end else if (!out_ready) begin
      if (stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL annotation_word_encoder");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_ann(ann_t a);
    int g;
    g = draw_gap(calm);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off input until every predicted word has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  task automatic write_shift(logic [SHIFT_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed forward steps, with long, backward, null and wild ones mixed in
  function automatic ann_t random_annotation();
    ann_t a;
    int   pick;
    pick = $urandom_range(0, 99);
    a.ann_type = TYPE_BITS'($urandom_range(1, 63));
    if (pick < 55) begin
      a.ann_time = prev_ann_time + $urandom_range(0, 1023);
    end else if (pick < 65) begin
      a.ann_time = prev_ann_time + $urandom_range(0, 1500);
      a.ann_type = NULL_ANN;
    end else if (pick < 75) begin
      a.ann_time = prev_ann_time +
                   ($urandom_range(0, 1) ? $urandom_range(1024, 70000) : $urandom);
    end else if (pick < 85) begin
      a.ann_time = prev_ann_time - $urandom_range(1, 5000);
    end else if (pick < 93) begin
      a.ann_time = $urandom;
      a.ann_type = TYPE_BITS'($urandom_range(0, 63));
    end else if (pick < 97) begin
      a.ann_time = '0;
    end else begin
      a.ann_time = prev_ann_time + $urandom_range(1023, 1024);
    end
    prev_ann_time = a.ann_time;
    return a;
  endfunction

  initial begin
    logic [SHIFT_BITS-1:0] shift_val;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // shift at reset value
    send_ann('{32'd0, 6'd1});
    send_ann('{32'd1, 6'd63});
    send_ann('{32'd1024, 6'd2});
    send_ann('{32'd2048, 6'd3});
    send_ann('{32'd2000, 6'd4});
    send_ann('{32'd2001, NULL_ANN});
    send_ann('{32'd2001, NULL_ANN});
    send_ann('{32'hFFFF_FFFF, 6'd63});
    send_ann('{32'd0, 6'd1});
    send_ann('{32'hAAAA_AAAA, NULL_ANN});
    send_ann('{32'h5555_5555, 6'd42});
    send_ann('{32'h5555_555A, 6'd21});

    write_shift(SHIFT_MAX);
    send_ann('{32'd0, 6'd9});
    send_ann('{32'd1, 6'd9});
    send_ann('{32'h7FFF_FFFF, 6'd9});
    send_ann('{32'hFFFF_FFFF, NULL_ANN});
    send_ann('{32'h8000_0000, 6'd17});
    send_ann('{32'h8000_0100, 6'd17});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       shift_val = '0;
        1:       shift_val = SHIFT_MAX;
        2:       shift_val = SHIFT_BITS'($urandom);
        default: shift_val = SHIFT_BITS'($urandom_range(0, 5000));
      endcase
      write_shift(shift_val);
      for (int i = 0; i < 100; i++) begin
        calm <= (ph % 2 == 1) && (i < 25);
        if (ph == 2 && i == 50) drain();
        send_ann(random_annotation());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("PASS annotation_word_encoder");
    end else begin
      $display("FAIL annotation_word_encoder");
    end
    $finish;
  end

endmodule

// File: annotation_word_encoder.f
src/awe_pkg.sv
src/awe_front.sv
src/awe_cmd_fifo.sv
src/awe_back.sv
src/annotation_word_encoder.sv
test/awe_word_checker.sv
test/tb_annotation_word_encoder.sv
